// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared definitions for the pressure/temperature compensation unit
// Holds the configuration register indexes, the sideband record that rides
// through the divider pipeline, and a 32-bit arithmetic shift helper.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam logic [2:0] REG_TEMP_CAL_1     = 3'd0;
  localparam logic [2:0] REG_TEMP_CAL_2     = 3'd1;
  localparam logic [2:0] REG_TEMP_CAL_3     = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_1    = 3'd3;
  localparam logic [2:0] REG_PRESS_CAL_2_3  = 3'd4;
  localparam logic [2:0] REG_PRESS_CAL_4_5  = 3'd5;
  localparam logic [2:0] REG_PRESS_CAL_6_7  = 3'd6;
  localparam logic [2:0] REG_PRESS_CAL_8_9  = 3'd7;

  localparam int unsigned DIV_STAGES = 32;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic        fault;
    logic        post_shift;
  } ptc_side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

// File: rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div: pipelined 32-bit unsigned divider
// Restoring division with one quotient bit per register stage, so a new
// transaction can enter every cycle that en_i is high. A sideband record travels alongside.
// ----------------------------------------------------------------------------
module ptc_div
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  ptc_side_t   side_i,
  output logic        valid_o,
  output logic [31:0] quotient_o,
  output ptc_side_t   side_o
);

  logic        vld_q  [DIV_STAGES];
  logic [31:0] rem_q  [DIV_STAGES];
  logic [31:0] num_q  [DIV_STAGES];
  logic [31:0] quo_q  [DIV_STAGES];
  logic [31:0] dvs_q  [DIV_STAGES];
  ptc_side_t   side_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic        vld_in;
    logic [31:0] rem_in, num_in, quo_in, dvs_in;
    ptc_side_t   side_in;
    logic [32:0] trial;
    logic        fits;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = dividend_i;
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_rest
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign num_in  = num_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign dvs_in  = dvs_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = {rem_in, num_in[31]};
    assign fits  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fits ? 32'(trial - {1'b0, dvs_in}) : trial[31:0];
        num_q[g]  <= {num_in[30:0], 1'b0};
        quo_q[g]  <= {quo_in[30:0], fits};
        dvs_q[g]  <= dvs_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[DIV_STAGES-1];
  assign quotient_o = quo_q[DIV_STAGES-1];
  assign side_o     = side_q[DIV_STAGES-1];

endmodule

// File: rtl/pressure_temperature_compensation_unit.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit: barometric sensor compensation
// Turns raw 20-bit pressure and temperature readings into fine temperature,
// centidegrees and pascals using the 32-bit integer compensation formulas.
// ----------------------------------------------------------------------------
// The unit accepts one reading pair per cycle and returns each result after
// 12 stages of temperature and pressure arithmetic (at most one
// multiplier level per stage), a 32-stage divider that produces one quotient
// bit per stage, and 3 stages of final pressure correction. A stall on the
// output freezes the whole pipeline. Calibration words must be written through
// the configuration port only while the unit is idle; the unit does not enforce this.
module pressure_temperature_compensation_unit
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_pressure_i,
  input  logic [19:0] raw_temperature_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] fine_temperature_o,
  output logic [31:0] temperature_centi_o,
  output logic [31:0] pressure_pa_o,
  output logic        divide_fault_o
);

  logic [15:0] t1_q, t2_q, t3_q, p1_q;
  logic [31:0] p23_q, p45_q, p67_q, p89_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0; t2_q <= '0; t3_q <= '0; p1_q <= '0;
      p23_q <= '0; p45_q <= '0; p67_q <= '0; p89_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEMP_CAL_1:    t1_q  <= cfg_data_i[15:0];
        REG_TEMP_CAL_2:    t2_q  <= cfg_data_i[15:0];
        REG_TEMP_CAL_3:    t3_q  <= cfg_data_i[15:0];
        REG_PRESS_CAL_1:   p1_q  <= cfg_data_i[15:0];
        REG_PRESS_CAL_2_3: p23_q <= cfg_data_i;
        REG_PRESS_CAL_4_5: p45_q <= cfg_data_i;
        REG_PRESS_CAL_6_7: p67_q <= cfg_data_i;
        REG_PRESS_CAL_8_9: p89_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] t2s, t3s, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
  assign t2s = {{16{t2_q[15]}}, t2_q};
  assign t3s = {{16{t3_q[15]}}, t3_q};
  assign p2s = {{16{p23_q[15]}}, p23_q[15:0]};
  assign p3s = {{16{p23_q[31]}}, p23_q[31:16]};
  assign p4s = {{16{p45_q[15]}}, p45_q[15:0]};
  assign p5s = {{16{p45_q[31]}}, p45_q[31:16]};
  assign p6s = {{16{p67_q[15]}}, p67_q[15:0]};
  assign p7s = {{16{p67_q[31]}}, p67_q[31:16]};
  assign p8s = {{16{p89_q[15]}}, p89_q[15:0]};
  assign p9s = {{16{p89_q[31]}}, p89_q[31:16]};

  // One enable for the whole pipeline: it advances unless a result is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [11:0] pre_vld_q;
  logic [19:0] adc_p1_q, adc_p2_q, adc_p3_q, adc_p4_q, adc_p5_q;
  logic [19:0] adc_p6_q, adc_p7_q, adc_p8_q, adc_p9_q;
  logic [31:0] s1_x_q, s1_d_q;
  logic [31:0] s2_m1_q, s2_dd_q;
  logic [31:0] s3_a_q, s3_m3_q;
  logic [31:0] s4_fine_q;
  logic [31:0] s5_fine_q, s5_f5_q, s5_a_q;
  logic [31:0] s6_fine_q, s6_temp_q, s6_sq_q, s6_m5_q, s6_m2_q;
  logic [31:0] s7_fine_q, s7_temp_q, s7_b1_q, s7_m3_q, s7_m5_q, s7_m2_q;
  logic [31:0] s8_fine_q, s8_temp_q, s8_b_q, s8_a_q;
  logic [31:0] s9_fine_q, s9_temp_q, s9_b_q, s9_am_q;
  logic [31:0] s10_fine_q, s10_temp_q, s10_dv_q, s10_num_q;
  logic [31:0] s11_fine_q, s11_temp_q, s11_dv_q, s11_pn_q;
  logic [31:0] s12_dvd_q, s12_dvs_q;
  ptc_side_t   s12_side_q;

  logic [31:0] s5_a_div4;
  assign s5_a_div4 = asr32(s5_a_q, 5'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else if (en) begin
      pre_vld_q <= {pre_vld_q[10:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: temperature differences.
      adc_p1_q <= raw_pressure_i;
      s1_x_q   <= 32'(raw_temperature_i[19:3]) - {15'd0, t1_q, 1'b0};
      s1_d_q   <= 32'(raw_temperature_i[19:4]) - {16'd0, t1_q};
      // Stage 2
      adc_p2_q <= adc_p1_q;
      s2_m1_q  <= s1_x_q * t2s;
      s2_dd_q  <= s1_d_q * s1_d_q;
      // Stage 3
      adc_p3_q <= adc_p2_q;
      s3_a_q   <= asr32(s2_m1_q, 5'd11);
      s3_m3_q  <= asr32(s2_dd_q, 5'd12) * t3s;
      // Stage 4: fine temperature.
      adc_p4_q  <= adc_p3_q;
      s4_fine_q <= s3_a_q + asr32(s3_m3_q, 5'd14);
      // Stage 5
      adc_p5_q  <= adc_p4_q;
      s5_fine_q <= s4_fine_q;
      s5_f5_q   <= s4_fine_q + {s4_fine_q[29:0], 2'b00};
      s5_a_q    <= asr32(s4_fine_q, 5'd1) - 32'd64000;
      // Stage 6
      adc_p6_q  <= adc_p5_q;
      s6_fine_q <= s5_fine_q;
      s6_temp_q <= asr32(s5_f5_q + 32'd128, 5'd8);
      s6_sq_q   <= s5_a_div4 * s5_a_div4;
      s6_m5_q   <= s5_a_q * p5s;
      s6_m2_q   <= p2s * s5_a_q;
      // Stage 7
      adc_p7_q  <= adc_p6_q;
      s7_fine_q <= s6_fine_q;
      s7_temp_q <= s6_temp_q;
      s7_b1_q   <= asr32(s6_sq_q, 5'd11) * p6s;
      s7_m3_q   <= p3s * asr32(s6_sq_q, 5'd13);
      s7_m5_q   <= s6_m5_q;
      s7_m2_q   <= s6_m2_q;
      // Stage 8
      adc_p8_q  <= adc_p7_q;
      s8_fine_q <= s7_fine_q;
      s8_temp_q <= s7_temp_q;
      s8_b_q    <= asr32(s7_b1_q + {s7_m5_q[30:0], 1'b0}, 5'd2) + {p4s[15:0], 16'd0};
      s8_a_q    <= asr32(asr32(s7_m3_q, 5'd3) + asr32(s7_m2_q, 5'd1), 5'd18);
      // Stage 9
      adc_p9_q  <= adc_p8_q;
      s9_fine_q <= s8_fine_q;
      s9_temp_q <= s8_temp_q;
      s9_b_q    <= s8_b_q;
      s9_am_q   <= (32'd32768 + s8_a_q) * {16'd0, p1_q};
      // Stage 10: divisor and numerator.
      s10_fine_q <= s9_fine_q;
      s10_temp_q <= s9_temp_q;
      s10_dv_q   <= asr32(s9_am_q, 5'd15);
      s10_num_q  <= (32'd1048576 - {12'd0, adc_p9_q}) - asr32(s9_b_q, 5'd12);
      // Stage 11
      s11_fine_q <= s10_fine_q;
      s11_temp_q <= s10_temp_q;
      s11_dv_q   <= s10_dv_q;
      s11_pn_q   <= s10_num_q * 32'd3125;
      // Stage 12: a large numerator is divided first and doubled afterward.
      s12_dvd_q             <= s11_pn_q[31] ? s11_pn_q : {s11_pn_q[30:0], 1'b0};
      s12_dvs_q             <= s11_dv_q;
      s12_side_q.fine       <= s11_fine_q;
      s12_side_q.temp       <= s11_temp_q;
      s12_side_q.fault      <= (s11_dv_q == '0);
      s12_side_q.post_shift <= s11_pn_q[31];
    end
  end

  logic        div_vld;
  logic [31:0] div_quo;
  ptc_side_t   div_side;

  ptc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (pre_vld_q[11]),
    .dividend_i (s12_dvd_q),
    .divisor_i  (s12_dvs_q),
    .side_i     (s12_side_q),
    .valid_o    (div_vld),
    .quotient_o (div_quo),
    .side_o     (div_side)
  );

  logic [1:0]  post_vld_q;
  logic [31:0] q1_p_q, q1_m9a_q, q1_m8_q;
  logic [31:0] q2_p_q, q2_m9_q, q2_m8_q;
  ptc_side_t   q1_side_q, q2_side_q;
  logic [31:0] pq, corr;

  assign pq   = div_side.post_shift ? {div_quo[30:0], 1'b0} : div_quo;
  assign corr = asr32(asr32(q2_m9_q, 5'd12) + asr32(q2_m8_q, 5'd13) + p7s, 5'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q  <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      post_vld_q  <= {post_vld_q[0], div_vld};
      out_valid_o <= post_vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_p_q    <= pq;
      q1_m9a_q  <= {3'd0, pq[31:3]} * {3'd0, pq[31:3]};
      q1_m8_q   <= {2'd0, pq[31:2]} * p8s;
      q1_side_q <= div_side;
      q2_p_q    <= q1_p_q;
      q2_m9_q   <= p9s * {13'd0, q1_m9a_q[31:13]};
      q2_m8_q   <= q1_m8_q;
      q2_side_q <= q1_side_q;
      fine_temperature_o  <= q2_side_q.fine;
      temperature_centi_o <= q2_side_q.temp;
      pressure_pa_o       <= q2_side_q.fault ? '0 : q2_p_q + corr;
      divide_fault_o      <= q2_side_q.fault;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> pressure_pa_o == '0)
    else $error("faulted result carries a nonzero pressure");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output is held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pressure_pa_o))
    else $error("held result changed");
`endif

endmodule

// File: tb/sv/tb_pressure_temperature_compensation_unit.sv
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation_unit: self-checking testbench
// Drives raw reading pairs through the compensation unit under bursty input
// and output stalls, predicts every result in 32-bit wrapping arithmetic and
// compares each output transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation_unit
  import ptc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PIPE_DRAIN = 60;
  localparam int unsigned RANDOM_ITEMS = 950;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic [31:0] press;
    logic        fault;
  } comp_result_t;

  typedef struct {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
    logic        known;
    comp_result_t res;
  } reading_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] raw_pressure_i = '0;
  logic [19:0] raw_temperature_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] fine_temperature_o;
  logic [31:0] temperature_centi_o;
  logic [31:0] pressure_pa_o;
  logic        divide_fault_o;

  pressure_temperature_compensation_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the calibration words.
  logic [15:0] dig_t1, dig_t2, dig_t3, dig_p1;
  logic [31:0] dig_p23, dig_p45, dig_p67, dig_p89;

  comp_result_t expected_q[$];
  int unsigned  errors = 0;
  int unsigned  checked = 0;
  int unsigned  faults_seen = 0;
  int unsigned  idle_cycles = 0;
  bit           hold_off = 1'b0;
  int unsigned  stall_pct = 30;

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_result_t compensate(logic [19:0] raw_p, logic [19:0] raw_t);
    logic [31:0] adc_p, adc_t, t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, temp, p, sq, dv;
    comp_result_t r;
    adc_p = {12'd0, raw_p};
    adc_t = {12'd0, raw_t};
    t2 = sext(dig_t2); t3 = sext(dig_t3);
    p2 = sext(dig_p23[15:0]); p3 = sext(dig_p23[31:16]);
    p4 = sext(dig_p45[15:0]); p5 = sext(dig_p45[31:16]);
    p6 = sext(dig_p67[15:0]); p7 = sext(dig_p67[31:16]);
    p8 = sext(dig_p89[15:0]); p9 = sext(dig_p89[31:16]);
    a = sra(((adc_t >> 3) - ({16'd0, dig_t1} << 1)) * t2, 11);
    d = (adc_t >> 4) - {16'd0, dig_t1};
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    temp = sra(fine * 32'd5 + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    sq = sra(a, 2) * sra(a, 2);
    b = sra(sq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
    dv = sra((32'd32768 + a) * {16'd0, dig_p1}, 15);
    r.fine = fine;
    r.temp = temp;
    if (dv == 0) begin
      r.fault = 1'b1;
      r.press = '0;
    end else begin
      r.fault = 1'b0;
      p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
      if (!p[31]) p = (p << 1) / dv;
      else p = (p / dv) * 32'd2;
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      r.press = p + sra(a + b + p7, 4);
    end
    return r;
  endfunction

  // The write enable stays high across back-to-back writes; load_cal drops it.
  task automatic write_cal(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_TEMP_CAL_1:    dig_t1 = val[15:0];
      REG_TEMP_CAL_2:    dig_t2 = val[15:0];
      REG_TEMP_CAL_3:    dig_t3 = val[15:0];
      REG_PRESS_CAL_1:   dig_p1 = val[15:0];
      REG_PRESS_CAL_2_3: dig_p23 = val;
      REG_PRESS_CAL_4_5: dig_p45 = val;
      REG_PRESS_CAL_6_7: dig_p67 = val;
      default:           dig_p89 = val;
    endcase
  endtask

  task automatic load_cal(logic [15:0] t1, logic [15:0] t2, logic [15:0] t3,
                          logic [15:0] p1, logic [31:0] p23, logic [31:0] p45,
                          logic [31:0] p67, logic [31:0] p89);
    write_cal(REG_TEMP_CAL_1, {16'($urandom_range(0, 65535)), t1});
    write_cal(REG_TEMP_CAL_2, {16'hdead, t2});
    write_cal(REG_TEMP_CAL_3, {16'h0, t3});
    write_cal(REG_PRESS_CAL_1, {16'hffff, p1});
    write_cal(REG_PRESS_CAL_2_3, p23);
    write_cal(REG_PRESS_CAL_4_5, p45);
    write_cal(REG_PRESS_CAL_6_7, p67);
    write_cal(REG_PRESS_CAL_8_9, p89);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline run dry.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic send_reading(logic [19:0] raw_p, logic [19:0] raw_t);
    in_valid_i <= 1'b1;
    raw_pressure_i <= raw_p;
    raw_temperature_i <= raw_t;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(compensate(raw_p, raw_t));
  endtask

  task automatic send_random(int unsigned count);
    int unsigned burst;
    int unsigned gap;
    int unsigned sent;
    logic [19:0] rp, rt;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        rp = $urandom_range(0, 3) == 0 ? 20'(($urandom_range(0, 1)) ? 20'hfffff : 20'h0)
                                       : 20'($urandom);
        // Mostly realistic temperature readings, sometimes any value.
        rt = $urandom_range(0, 2) == 0 ? 20'($urandom) : 20'($urandom_range(400000, 600000));
        send_reading(rp, rt);
        sent++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Output checker.
  always @(posedge clk_i) begin
    comp_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result fine=%h temp=%h press=%h fault=%b", $time,
                 fine_temperature_o, temperature_centi_o, pressure_pa_o, divide_fault_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (divide_fault_o) faults_seen++;
        if (fine_temperature_o !== exp_r.fine) begin
          $display("%0t: fine_temperature expected %h actual %h", $time, exp_r.fine,
                   fine_temperature_o);
          errors++;
        end
        if (temperature_centi_o !== exp_r.temp) begin
          $display("%0t: temperature_centi expected %h actual %h", $time, exp_r.temp,
                   temperature_centi_o);
          errors++;
        end
        if (pressure_pa_o !== exp_r.press) begin
          $display("%0t: pressure_pa expected %h actual %h", $time, exp_r.press,
                   pressure_pa_o);
          errors++;
        end
        if (divide_fault_o !== exp_r.fault) begin
          $display("%0t: divide_fault expected %b actual %b", $time, exp_r.fault,
                   divide_fault_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_q.size());
      $display("pressure_temperature_compensation_unit verification failed");
      $finish;
    end
  end

  initial begin
    reading_row_t directed[$];
    reading_row_t row;
    comp_result_t got;
    dig_t1 = '0; dig_t2 = '0; dig_t3 = '0; dig_p1 = '0;
    dig_p23 = '0; dig_p45 = '0; dig_p67 = '0; dig_p89 = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset all words are zero: fine is zero and the divisor is zero.
    directed.push_back('{20'h0, 20'h0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}});
    directed.push_back('{20'hfffff, 20'hfffff, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}});
    foreach (directed[i]) begin
      row = directed[i];
      got = compensate(row.raw_p, row.raw_t);
      if (row.known && got !== row.res) begin
        $display("%0t: reset row %0d expected %h actual %h", $time, i, row.res, got);
        errors++;
      end
      send_reading(row.raw_p, row.raw_t);
    end
    in_valid_i <= 1'b0;
    drain();

    // Typical datasheet calibration.
    load_cal(16'd27504, 16'd26435, -16'sd1000, 16'd36477, {-16'sd10685, -16'sd3970},
             {-16'sd7, 16'd2855}, {16'd15500, 16'd140}, {16'd6000, -16'sd14600});
    directed.delete();
    directed.push_back('{20'd415148, 20'd519888, 1'b0, '0});
    directed.push_back('{20'h0, 20'h0, 1'b0, '0});
    directed.push_back('{20'hfffff, 20'hfffff, 1'b0, '0});
    directed.push_back('{20'h0, 20'hfffff, 1'b0, '0});
    directed.push_back('{20'hfffff, 20'h0, 1'b0, '0});
    directed.push_back('{20'h55555, 20'haaaaa, 1'b0, '0});
    directed.push_back('{20'haaaaa, 20'h55555, 1'b0, '0});
    foreach (directed[i]) send_reading(directed[i].raw_p, directed[i].raw_t);
    in_valid_i <= 1'b0;
    drain();

    // Extreme words: largest and smallest signed values.
    load_cal(16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 32'h7fff7fff, 32'h7fff7fff,
             32'h7fff7fff, 32'h7fff7fff);
    for (int i = 0; i < 4; i++) send_reading(20'(i * 20'h55555), 20'hfffff - 20'(i * 20'h55555));
    in_valid_i <= 1'b0;
    drain();
    load_cal(16'h0, 16'h8000, 16'h8000, 16'h8000, 32'h80008000, 32'h80008000,
             32'h80008000, 32'h80008000);
    for (int i = 0; i < 4; i++) send_reading(20'(i * 20'h33333), 20'(i * 20'h44444));
    in_valid_i <= 1'b0;
    drain();
    // Scale factor zero forces the zero-divisor fault with a real temperature.
    load_cal(16'd27504, 16'd26435, -16'sd1000, 16'd0, 32'hf07fd64b, 32'hfff90b27,
             32'h008c3c8c, 32'hc6f81770);
    send_reading(20'd415148, 20'd519888);
    in_valid_i <= 1'b0;
    drain();

    // Random phases: datasheet-like words, then fully random words.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 2)
        load_cal(16'(27000 + $urandom_range(0, 1000)), 16'(26000 + $urandom_range(0, 900)),
                 -16'sd1000, 16'(36000 + $urandom_range(0, 900)), 32'hf07fd64b,
                 32'hfff90b27, {16'd15500, 16'(100 + $urandom_range(0, 80))},
                 32'hc6f81770);
      else
        load_cal(16'($urandom), 16'($urandom), 16'($urandom),
                 ph == 4 ? 16'($urandom_range(0, 3)) : 16'($urandom), $urandom,
                 $urandom, $urandom, $urandom);
      stall_pct = ph == 3 ? 0 : $urandom_range(10, 60);
      if (ph == 1) begin
        // Long receiver hold-off while the sender keeps offering.
        fork
          send_random(RANDOM_ITEMS / 5);
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join
      end else begin
        send_random(RANDOM_ITEMS / 5);
      end
      drain();
    end

    $display("Checked %0d results (%0d divide faults) over reset, extreme and random",
             checked, faults_seen);
    $display("calibration sets with bursty input and stalled output.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("pressure_temperature_compensation_unit verification clean");
    end else begin
      $display("pressure_temperature_compensation_unit verification failed");
    end
    $finish;
  end

endmodule
